// ===== src/rational_arithmetic_unit_defines.svh =====
// Assertion macros shared by the rational arithmetic unit RTL.
// Depends on nothing; include with the bare file name.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
// Implication checked at every edge outside reset.
`define RAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define RAU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/rau_pkg.sv =====
// Package for the rational arithmetic unit: command and status codes,
// sequencer states. Used by rau_divider and rational_arithmetic_unit.
package rau_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned CmdW = 4;

  typedef enum logic [3:0] {
    CMD_NORM = 4'd0, CMD_ADD = 4'd1, CMD_SUB = 4'd2, CMD_MUL = 4'd3,
    CMD_DIV = 4'd4, CMD_EQ = 4'd5, CMD_LT = 4'd6, CMD_LE = 4'd7,
    CMD_GT = 4'd8, CMD_GE = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ZERO_DEN = 2'd1, ST_DIV_ZERO = 2'd2, ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RED_A, S_GCD_A, S_DIVN_A, S_DIVD_A, S_RED_B, S_GCD_B, S_DIVN_B,
    S_DIVD_B, S_MUL_X, S_MUL_Y, S_MUL_D, S_COMBINE, S_GCD_R, S_DIVN_R,
    S_DIVD_R, S_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

// ===== src/rau_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit operands.
// Depends on rau_pkg and rational_arithmetic_unit_defines.svh.
module rau_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rau_pkg::WordW-1:0]  dividend,
  input  logic [rau_pkg::WordW-1:0]  divisor,
  output rau_pkg::div_ctl_t          ctl,
  output logic [rau_pkg::WordW-1:0]  quotient,
  output logic [rau_pkg::WordW-1:0]  remainder
);
  import rau_pkg::*;
  `include "rational_arithmetic_unit_defines.svh"

  localparam int unsigned CntW = $clog2(WordW + 1);

  logic [CntW-1:0]  count;
  logic             busy;
  logic             done;
  logic [WordW-1:0] quo;
  logic [WordW-1:0] rem;
  logic [WordW-1:0] dvs;
  logic [WordW:0]   trial;
  logic [WordW:0]   shifted;

  assign shifted = {rem, quo[WordW-1]};
  assign trial = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        count <= CntW'(WordW);
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
      end else if (busy) begin
        // shift one dividend bit into the partial remainder
        if (!trial[WordW]) begin
          rem <= trial[WordW-1:0];
          quo <= {quo[WordW-2:0], 1'b1};
        end else begin
          rem <= shifted[WordW-1:0];
          quo <= {quo[WordW-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ctl.start = start;
  assign ctl.busy = busy;
  assign ctl.done = done;
  assign quotient = quo;
  assign remainder = rem;

  `RAU_ASSERT_IMP(a_done_not_busy, done, !busy, "divider done while busy")
  `RAU_ASSERT_NXT(a_start_busy, start && !busy, busy, "divider did not start")
  `RAU_ASSERT_IMP(a_count_range, busy, count != '0, "divider count ran out")
endmodule

// ===== src/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: sequencer, operand registers, one shared divider.
// Depends on rau_pkg, rau_divider and rational_arithmetic_unit_defines.svh.
//
// Usage: drive command and the four operand fields and raise start while
// busy is low; that edge takes the beat. busy stays high until the result
// beat, which sits on res_num, res_den, compare_true and status for exactly
// one cycle with done high. The receiver cannot stall; take it then.
// Each reduction of a nonzero numerator runs a Euclid gcd, every step one
// pass of the shared restoring divider, then two more divisions to reduce
// numerator and denominator; a gcd of 64-bit values may need up to about 92
// steps. A zero denominator goes from S_RED_A straight to S_EMIT; division
// by zero is found in S_RED_B, only once operand A is reduced.
// Throughput: one operation at a time; a new start is taken the cycle after
// done. Reset (rst, synchronous) returns the sequencer to idle, drops any
// operation in flight and clears done; no result is emitted for it.
module rational_arithmetic_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [3:0]          command,
  input  logic signed [31:0]  a_num,
  input  logic signed [31:0]  a_den,
  input  logic signed [31:0]  b_num,
  input  logic signed [31:0]  b_den,
  output logic                busy,
  output logic                done,
  output logic signed [31:0]  res_num,
  output logic [30:0]         res_den,
  output logic                compare_true,
  output logic [1:0]          status
);
  import rau_pkg::*;
  `include "rational_arithmetic_unit_defines.svh"

  state_t state, state_next;

  // operand and working registers (magnitudes plus sign)
  cmd_t             cmd;
  logic [31:0]      in_bn, in_bd;
  logic             a_neg, b_neg, r_neg;
  logic [WordW-1:0] a_n, a_d, b_n, b_d;
  logic [WordW-1:0] g_x, g_y;          // Euclid pair
  logic [WordW-1:0] w_n, w_d;          // fraction under reduction
  logic [WordW-1:0] px, py;            // products (cross products but for CMD_MUL)
  logic [1:0]       sel;
  logic [1:0]       st_code;
  logic             cmp_bit;

  // shared divider
  div_ctl_t         dctl;
  logic             d_start;
  logic [WordW-1:0] d_dividend, d_divisor, d_quo, d_rem;

  rau_divider u_div (
    .clk(clk), .rst(rst), .start(d_start), .dividend(d_dividend),
    .divisor(d_divisor), .ctl(dctl), .quotient(d_quo), .remainder(d_rem)
  );

  // magnitude of a 32-bit two's complement value
  function automatic logic [WordW-1:0] mag32(input logic [31:0] v);
    logic [32:0] m;
    m = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    return {{(WordW-33){1'b0}}, m};
  endfunction

  logic [31:0] cmd_ext;
  assign cmd_ext = {28'd0, command};

  // one 32x32 multiplier, used for each product in turn
  logic [31:0] m_op1, m_op2;
  logic [63:0] m_prod;
  assign m_prod = m_op1 * m_op2;

  always_comb begin
    unique case (state)
      S_MUL_X: begin
        m_op1 = (cmd == CMD_DIV) ? a_n[31:0] : a_n[31:0];
        m_op2 = (cmd == CMD_MUL) ? b_n[31:0] : b_d[31:0];
      end
      S_MUL_Y: begin
        m_op1 = (cmd == CMD_MUL) ? a_d[31:0] : b_n[31:0];
        m_op2 = (cmd == CMD_MUL) ? b_d[31:0] : a_d[31:0];
      end
      S_MUL_D: begin
        m_op1 = a_d[31:0];
        m_op2 = b_d[31:0];
      end
      default: begin
        m_op1 = '0;
        m_op2 = '0;
      end
    endcase
  end

  logic [WordW-1:0] sum_xy, dif_xy, dif_yx;
  logic             same_sign, bsign;
  assign bsign = (cmd == CMD_ADD) ? b_neg : !b_neg;
  assign same_sign = (bsign == a_neg);
  assign sum_xy = px + py;
  assign dif_xy = px - py;
  assign dif_yx = py - px;

  // numerator that the combine step writes
  logic [WordW-1:0] comb_n;
  assign comb_n = (cmd == CMD_MUL || cmd == CMD_DIV) ? px :
                  same_sign ? sum_xy : (px >= py) ? dif_xy : dif_yx;

  // divider operands by state
  always_comb begin
    d_start = 1'b0;
    d_dividend = g_x;
    d_divisor = g_y;
    unique case (state)
      S_GCD_A, S_GCD_B, S_GCD_R: d_start = !dctl.busy && !dctl.done && (g_y != '0);
      S_DIVN_A, S_DIVN_B, S_DIVN_R: begin
        d_start = !dctl.busy && !dctl.done;
        d_dividend = w_n;
        d_divisor = g_x;
      end
      S_DIVD_A, S_DIVD_B, S_DIVD_R: begin
        d_start = !dctl.busy && !dctl.done;
        d_dividend = w_d;
        d_divisor = g_x;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start && !done) state_next = S_RED_A;
      S_RED_A: begin
        if (st_code != ST_OK) state_next = S_EMIT;
        else if (w_n == '0) state_next = (cmd == CMD_NORM) ? S_EMIT : S_RED_B;
        else state_next = S_GCD_A;
      end
      S_GCD_A: if (g_y == '0) state_next = S_DIVN_A;
      S_DIVN_A: if (dctl.done) state_next = S_DIVD_A;
      S_DIVD_A: if (dctl.done) state_next = (cmd == CMD_NORM) ? S_EMIT : S_RED_B;
      S_RED_B: begin
        if (w_n == '0) state_next = (cmd == CMD_DIV) ? S_EMIT : S_MUL_X;
        else state_next = S_GCD_B;
      end
      S_GCD_B: if (g_y == '0) state_next = S_DIVN_B;
      S_DIVN_B: if (dctl.done) state_next = S_DIVD_B;
      S_DIVD_B: if (dctl.done) state_next = S_MUL_X;
      S_MUL_X: state_next = S_MUL_Y;
      S_MUL_Y: state_next = S_MUL_D;
      S_MUL_D: state_next = S_COMBINE;
      S_COMBINE: state_next = (comb_n == '0) ? S_EMIT : S_GCD_R;
      S_GCD_R: if (g_y == '0) state_next = S_DIVN_R;
      S_DIVN_R: if (dctl.done) state_next = S_DIVD_R;
      S_DIVD_R: if (dctl.done) state_next = S_EMIT;
      S_EMIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  logic is_cmp;
  assign is_cmp = (cmd == CMD_EQ) || (cmd == CMD_LT) || (cmd == CMD_LE) ||
                  (cmd == CMD_GT) || (cmd == CMD_GE);

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    unique case (state)
      S_IDLE: if (start && !done) begin
        cmd <= (cmd_ext > 32'd9) ? CMD_NORM : cmd_t'(command);
        in_bn <= b_num;
        in_bd <= b_den;
        a_neg <= a_num[31] != a_den[31];
        w_n <= mag32(a_num);
        w_d <= mag32(a_den);
        g_x <= mag32(a_num);
        g_y <= mag32(a_den);
        st_code <= ST_OK;
        if (a_den == '0 || (cmd_ext <= 32'd9 && command != CMD_NORM && b_den == '0))
          st_code <= ST_ZERO_DEN;
      end
      S_RED_A, S_RED_B: begin
        if (w_n == '0) begin
          if (state == S_RED_A) begin a_neg <= 1'b0; a_n <= '0; a_d <= 64'd1; end
          else begin b_neg <= 1'b0; b_n <= '0; b_d <= 64'd1; end
        end
        if (state == S_RED_A && st_code == ST_OK && w_n == '0 && cmd != CMD_NORM) begin
          b_neg <= in_bn[31] != in_bd[31];
          w_n <= mag32(in_bn);
          w_d <= mag32(in_bd);
          g_x <= mag32(in_bn);
          g_y <= mag32(in_bd);
        end
        if (state == S_RED_B && w_n == '0 && cmd == CMD_DIV) st_code <= ST_DIV_ZERO;
      end
      S_GCD_A, S_GCD_B, S_GCD_R: if (dctl.done) begin
        // advance Euclid: (x, y) <- (y, x mod y)
        g_x <= g_y;
        g_y <= d_rem;
      end
      S_DIVN_A, S_DIVN_B, S_DIVN_R: if (dctl.done) w_n <= d_quo;
      S_DIVD_A: if (dctl.done) begin
        a_n <= w_n;
        a_d <= d_quo;
        b_neg <= in_bn[31] != in_bd[31];
        w_n <= mag32(in_bn);
        w_d <= mag32(in_bd);
        g_x <= mag32(in_bn);
        g_y <= mag32(in_bd);
      end
      S_DIVD_B: if (dctl.done) begin
        b_n <= w_n;
        b_d <= d_quo;
      end
      S_MUL_X: px <= m_prod;
      S_MUL_Y: py <= m_prod;
      S_MUL_D: w_d <= m_prod;
      S_COMBINE: begin
        if (cmd == CMD_MUL || cmd == CMD_DIV) begin
          r_neg <= a_neg != b_neg;
          w_n <= px;
          w_d <= py;
          g_x <= px;
          g_y <= py;
        end else begin
          if (same_sign) begin r_neg <= a_neg; w_n <= sum_xy; g_x <= sum_xy; end
          else if (px >= py) begin r_neg <= a_neg; w_n <= dif_xy; g_x <= dif_xy; end
          else begin r_neg <= bsign; w_n <= dif_yx; g_x <= dif_yx; end
          g_y <= w_d;
        end
      end
      S_DIVD_R: if (dctl.done) w_d <= d_quo;
      default: ;
    endcase
  end

  // result formatting for the emit cycle
  logic             f_neg;
  logic [WordW-1:0] f_n, f_d;
  logic             ovf;
  logic             r_zero;
  always_comb begin
    f_neg = r_neg;
    f_n = w_n;
    f_d = w_d;
    if (cmd == CMD_NORM) begin
      f_neg = a_neg;
      f_n = a_n;
      f_d = a_d;
    end
    r_zero = (f_n == '0);
    if (r_zero) begin
      f_neg = 1'b0;
      f_d = 64'd1;
    end
    ovf = (f_d > 64'h7FFF_FFFF) ||
          (f_neg ? (f_n > 64'h8000_0000) : (f_n > 64'h7FFF_FFFF));
  end

  always_comb begin
    unique case (cmd)
      CMD_EQ: cmp_bit = r_zero;
      CMD_LT: cmp_bit = !r_zero && f_neg;
      CMD_LE: cmp_bit = r_zero || f_neg;
      CMD_GT: cmp_bit = !r_zero && !f_neg;
      default: cmp_bit = r_zero || !f_neg;
    endcase
  end

  // output stage: one-cycle result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_EMIT);
    end
    if (state == S_EMIT) begin
      res_num <= '0;
      res_den <= '0;
      compare_true <= 1'b0;
      status <= st_code;
      if (st_code == ST_OK) begin
        if (is_cmp) compare_true <= cmp_bit;
        else if (ovf) status <= ST_OVERFLOW;
        else begin
          res_num <= f_neg ? 32'(64'h1_0000_0000 - f_n) : f_n[31:0];
          res_den <= f_d[30:0];
        end
      end
    end
  end

  assign busy = (state != S_IDLE) || done;

  `RAU_ASSERT_NXT(a_emit_done, state == S_EMIT, done, "result beat missing")
  `RAU_ASSERT_IMP(a_done_busy_idle, done, state == S_IDLE, "done outside idle")
  `RAU_ASSERT_IMP(a_err_zero, done && status != ST_OK, res_num == '0 && res_den == '0,
                  "error beat carries data")
  `RAU_ASSERT_IMP(a_div_idle, state == S_IDLE, !dctl.busy, "divider busy in idle")
endmodule
